// ----- rtl/vfv_pkg.sv -----
// Shared types and constants for the voxel face visibility block.
// No dependencies.
`timescale 1ns / 1ps
package vfv_pkg;
  localparam int unsigned FuncW = 2;
  localparam logic [1:0] FUNC_LOAD_VOXEL  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_BORDER = 2'd1;
  localparam logic [1:0] FUNC_QUERY       = 2'd2;

  localparam logic [1:0] SIDE_FRONT = 2'd0;
  localparam logic [1:0] SIDE_BACK  = 2'd1;
  localparam logic [1:0] SIDE_LEFT  = 2'd2;
  localparam logic [1:0] SIDE_RIGHT = 2'd3;

  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CHUNK_POS  = 2'd2;

  localparam int unsigned FACE_FRONT  = 0;
  localparam int unsigned FACE_BACK   = 1;
  localparam int unsigned FACE_TOP    = 2;
  localparam int unsigned FACE_BOTTOM = 3;
  localparam int unsigned FACE_LEFT   = 4;
  localparam int unsigned FACE_RIGHT  = 5;

  localparam int unsigned InW  = 32;  // 26 field bits padded to bytes
  localparam int unsigned OutW = 24;  // 17 field bits padded to bytes

  // Presence request and answer between top level and presence unit.
  typedef struct packed {
    logic        start;
    logic [10:0] width;
    logic [10:0] height;
    logic [19:0] pos;
  } pres_req_t;

  typedef struct packed {
    logic       busy;
    logic [3:0] present;
  } pres_rsp_t;
endpackage

// ----- rtl/vfv_presence.sv -----
// Neighbor presence unit: splits the chunk position into row and column with
// a restoring divider, one quotient bit per cycle. Depends on vfv_pkg.
`timescale 1ns / 1ps
module vfv_presence (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vfv_pkg::pres_req_t req_i,
  output vfv_pkg::pres_rsp_t rsp_o
);
  import vfv_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EVAL = 3'b100
  } pst_e;

  pst_e        state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [19:0] quo_q, quo_d;
  logic [20:0] rem_q, rem_d;
  logic [10:0] w_q, w_d, h_q, h_d;
  logic [3:0]  pres_q, pres_d;
  logic [20:0] shifted;
  logic [20:0] row_w, col_w;

  assign shifted = {rem_q[19:0], quo_q[19]};
  assign row_w   = {1'b0, quo_q};
  assign col_w   = rem_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    w_d     = w_q;
    h_d     = h_q;
    pres_d  = pres_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          w_d     = req_i.width;
          h_d     = req_i.height;
          quo_d   = req_i.pos;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (w_q == '0) begin
          pres_d  = '0;
          state_d = ST_IDLE;
        end else begin
          if (shifted >= {10'd0, w_q}) begin
            rem_d = shifted - {10'd0, w_q};
            quo_d = {quo_q[18:0], 1'b1};
          end else begin
            rem_d = shifted;
            quo_d = {quo_q[18:0], 1'b0};
          end
          cnt_d = cnt_q + 5'd1;
          if (cnt_q == 5'd19) state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // Column is always below the width here, row is never negative.
        pres_d[SIDE_FRONT] = (row_w != '0) && ((row_w - 21'd1) < {10'd0, h_q});
        pres_d[SIDE_BACK]  = (row_w + 21'd1) < {10'd0, h_q};
        pres_d[SIDE_LEFT]  = (row_w < {10'd0, h_q}) && (col_w != '0);
        pres_d[SIDE_RIGHT] = (row_w < {10'd0, h_q}) &&
                             ((col_w + 21'd1) < {10'd0, w_q});
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pres_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pres_q  <= pres_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    w_q   <= w_d;
    h_q   <= h_d;
  end

  assign rsp_o.busy    = (state_q != ST_IDLE) || req_i.start;
  assign rsp_o.present = pres_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 5'd20) else $error("divider count overran");
  a_eval_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EVAL |=> state_q == ST_IDLE) else $error("eval did not finish");
  a_zero_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && w_q == '0) |=> pres_q == '0)
    else $error("zero width left a neighbor present");
endmodule

// ----- rtl/voxel_face_visibility.sv -----
// Top level of the voxel face visibility block: voxel and border memories,
// query sequencer and output register. Depends on vfv_pkg and vfv_presence.
`timescale 1ns / 1ps
// A load takes one beat, so loads can follow back to back. A query reads the
// voxel itself and then one neighbor per face from the single-ported voxel
// memory or the border memory, one read a cycle; a top or bottom face at the
// chunk edge, or a side face with no neighbor chunk, takes a fixed answer. Its
// result is offered after the self, face, last and output states, and the next
// beat can be taken in that same cycle. An air voxel skips the face states, an
// out-of-range coordinate all reads. A finished query waits whenever the output
// register still holds an earlier result. A register write starts a neighbor
// recomputation, and no item is taken until it ends; the same holds after reset.
module voxel_face_visibility #(
  parameter int unsigned CHUNK_X_SIZE = 16,
  parameter int unsigned CHUNK_Y_SIZE = 64,
  parameter int unsigned CHUNK_Z_SIZE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] func, [5:2] vox_x, [11:6] vox_y, [15:12] vox_z, [17:16] side,
  // [25:18] block_value, upper bits zero
  input  logic [vfv_pkg::InW-1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] visible_mask, [13:6] block_id, [16:14] face_total, upper bits zero
  output logic [vfv_pkg::OutW-1:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);
  import vfv_pkg::*;

  localparam int unsigned XW = (CHUNK_X_SIZE > 1) ? $clog2(CHUNK_X_SIZE) : 1;
  localparam int unsigned YW = (CHUNK_Y_SIZE > 1) ? $clog2(CHUNK_Y_SIZE) : 1;
  localparam int unsigned ZW = (CHUNK_Z_SIZE > 1) ? $clog2(CHUNK_Z_SIZE) : 1;
  localparam int unsigned SpanXz = (CHUNK_X_SIZE > CHUNK_Z_SIZE) ?
                                   CHUNK_X_SIZE : CHUNK_Z_SIZE;
  localparam int unsigned AW = (SpanXz > 1) ? $clog2(SpanXz) : 1;
  localparam int unsigned StoreSize = CHUNK_X_SIZE * CHUNK_Y_SIZE * CHUNK_Z_SIZE;
  localparam int unsigned PlaneSize = SpanXz * CHUNK_Y_SIZE;
  localparam int unsigned VAW = $clog2(StoreSize);
  localparam int unsigned BAW = $clog2(4 * PlaneSize);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SELF  = 5'b00010,
    ST_FACE  = 5'b00100,
    ST_LAST  = 5'b01000,
    ST_OUT   = 5'b10000
  } st_e;

  // Input fields
  logic [1:0] f_func, f_side;
  logic [3:0] f_x, f_z;
  logic [5:0] f_y;
  logic [7:0] f_val;
  assign f_func = s_axis_tdata[1:0];
  assign f_x    = s_axis_tdata[5:2];
  assign f_y    = s_axis_tdata[11:6];
  assign f_z    = s_axis_tdata[15:12];
  assign f_side = s_axis_tdata[17:16];
  assign f_val  = s_axis_tdata[25:18];

  // Configuration and presence
  logic [10:0] map_w_q, map_h_q;
  logic [19:0] pos_q;
  logic        pres_start_q;
  pres_req_t   pres_req;
  pres_rsp_t   pres_rsp;

  // Sequencer
  st_e        state_q, state_d;
  logic [2:0] face_q, face_d;       // face whose read is issued this cycle
  logic [2:0] rface_q;              // face whose read data arrives now
  logic       rvalid_q, rborder_q;  // read issued last cycle, from border mem
  logic       rdirect_q;            // last cycle's face has a fixed answer
  logic       rdval_q;
  logic [XW-1:0] qx_q;
  logic [YW-1:0] qy_q;
  logic [ZW-1:0] qz_q;
  logic [5:0] mask_q, mask_d;
  logic [7:0] id_q, id_d;
  logic       out_valid_q;
  logic [5:0] out_mask_q;
  logic [7:0] out_id_q;
  logic [2:0] out_total_q;

  // Memories
  logic [7:0] vmem [StoreSize];
  logic [7:0] bmem [4 * PlaneSize];
  logic [7:0] vrd_q, brd_q;
  logic       vwe, bwe;
  logic [VAW-1:0] vaddr;
  logic [BAW-1:0] baddr;
  logic [7:0]     wval;
  logic           in_acc, busy, inrange;

  assign busy = pres_rsp.busy || pres_start_q;
  assign s_axis_tready = (state_q == ST_IDLE) && !busy && !cfg_valid_i;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = (state_q == ST_IDLE) && !out_valid_q && !pres_start_q &&
                       !pres_rsp.busy;

  assign inrange = ({28'd0, f_x} < 32'(CHUNK_X_SIZE)) &&
                   ({26'd0, f_y} < 32'(CHUNK_Y_SIZE)) &&
                   ({28'd0, f_z} < 32'(CHUNK_Z_SIZE));

  function automatic logic [VAW-1:0] vidx(input logic [XW:0] x,
                                          input logic [YW:0] y,
                                          input logic [ZW:0] z);
    vidx = VAW'((32'(y) * CHUNK_Z_SIZE + 32'(z)) * CHUNK_X_SIZE + 32'(x));
  endfunction

  // Neighbor address for face f of the latched query
  logic [XW:0] nx;
  logic [YW:0] ny;
  logic [ZW:0] nz;
  logic        n_in, n_fixed, n_fix_val, n_border;
  logic [1:0]  n_side;
  logic [AW:0] n_a;
  logic [BAW-1:0] n_baddr;

  always_comb begin
    nx = {1'b0, qx_q};
    ny = {1'b0, qy_q};
    nz = {1'b0, qz_q};
    n_side = SIDE_FRONT;
    case (face_q)
      3'(FACE_FRONT):  begin nz = nz - (ZW + 1)'(1); n_side = SIDE_FRONT; end
      3'(FACE_BACK):   begin nz = nz + (ZW + 1)'(1); n_side = SIDE_BACK;  end
      3'(FACE_TOP):    ny = ny + (YW + 1)'(1);
      3'(FACE_BOTTOM): ny = ny - (YW + 1)'(1);
      3'(FACE_LEFT):   begin nx = nx - (XW + 1)'(1); n_side = SIDE_LEFT;  end
      3'(FACE_RIGHT):  begin nx = nx + (XW + 1)'(1); n_side = SIDE_RIGHT; end
      default: ;
    endcase
    // Wrapped negative values land at or above the size, so one compare does.
    n_in = (32'(nx) < 32'(CHUNK_X_SIZE)) && (32'(ny) < 32'(CHUNK_Y_SIZE)) &&
           (32'(nz) < 32'(CHUNK_Z_SIZE));
    n_border  = 1'b0;
    n_fixed   = 1'b0;
    n_fix_val = 1'b0;
    if (!n_in) begin
      if (face_q == 3'(FACE_TOP)) begin
        n_fixed = 1'b1; n_fix_val = 1'b1;
      end else if (face_q == 3'(FACE_BOTTOM) || !pres_rsp.present[n_side]) begin
        n_fixed = 1'b1;
      end else begin
        n_border = 1'b1;
      end
    end
    n_a = (n_side == SIDE_FRONT || n_side == SIDE_BACK) ?
          (AW + 1)'(qx_q) : (AW + 1)'(qz_q);
    n_baddr = BAW'(32'(n_side) * PlaneSize + 32'(qy_q) * SpanXz + 32'(n_a));
  end

  // Memory port control
  always_comb begin
    vwe   = 1'b0;
    bwe   = 1'b0;
    wval  = f_val;
    vaddr = vidx({1'b0, XW'(f_x)}, {1'b0, YW'(f_y)}, {1'b0, ZW'(f_z)});
    baddr = BAW'(32'(f_side) * PlaneSize + 32'(f_y) * SpanXz +
                 ((f_side == SIDE_FRONT || f_side == SIDE_BACK) ?
                  32'(f_x) : 32'(f_z)));
    if (in_acc && f_func == FUNC_LOAD_VOXEL && inrange) vwe = 1'b1;
    if (in_acc && f_func == FUNC_LOAD_BORDER && ({26'd0, f_y} < 32'(CHUNK_Y_SIZE)) &&
        (((f_side == SIDE_FRONT || f_side == SIDE_BACK) &&
          ({28'd0, f_x} < 32'(CHUNK_X_SIZE))) ||
         ((f_side == SIDE_LEFT || f_side == SIDE_RIGHT) &&
          ({28'd0, f_z} < 32'(CHUNK_Z_SIZE))))) bwe = 1'b1;
    if (state_q == ST_FACE) begin
      vaddr = vidx(nx, ny, nz);
      baddr = n_baddr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vwe) vmem[vaddr] <= wval;
    vrd_q <= vmem[vaddr];
  end

  always_ff @(posedge clk_i) begin
    if (bwe) bmem[baddr] <= wval;
    brd_q <= bmem[baddr];
  end

  // Answer of the face whose data arrives this cycle
  logic rvis;
  assign rvis = rdirect_q ? rdval_q : (rborder_q ? (brd_q == 8'd0) : (vrd_q == 8'd0));

  always_comb begin
    state_d = state_q;
    face_d  = face_q;
    mask_d  = mask_q;
    id_d    = id_q;
    unique case (state_q)
      ST_IDLE: begin
        mask_d = '0;
        id_d   = '0;
        face_d = '0;
        if (in_acc && f_func == FUNC_QUERY)
          state_d = inrange ? ST_SELF : ST_OUT;
      end
      ST_SELF: begin
        id_d    = vrd_q;
        state_d = (vrd_q == 8'd0) ? ST_OUT : ST_FACE;
      end
      ST_FACE: begin
        if (rvalid_q && rvis) mask_d[rface_q] = 1'b1;
        face_d = face_q + 3'd1;
        if (face_q == 3'(FACE_RIGHT)) state_d = ST_LAST;
      end
      ST_LAST: begin
        if (rvis) mask_d[rface_q] = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      rvalid_q     <= 1'b0;
      map_w_q      <= 11'd1;
      map_h_q      <= 11'd1;
      pos_q        <= '0;
      pres_start_q <= 1'b1;
    end else begin
      state_q  <= state_d;
      rvalid_q <= (state_q == ST_FACE);
      pres_start_q <= cfg_valid_i && cfg_ready_o &&
                      (cfg_index_i == REG_MAP_WIDTH || cfg_index_i == REG_MAP_HEIGHT ||
                       cfg_index_i == REG_CHUNK_POS);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_MAP_WIDTH:  map_w_q <= cfg_data_i[10:0];
          REG_MAP_HEIGHT: map_h_q <= cfg_data_i[10:0];
          REG_CHUNK_POS:  pos_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_OUT && !out_valid_q) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    face_q    <= face_d;
    mask_q    <= mask_d;
    id_q      <= id_d;
    rface_q   <= face_q;
    rborder_q <= n_border;
    rdirect_q <= n_fixed;
    rdval_q   <= n_fix_val;
    if (in_acc) begin
      qx_q <= XW'(f_x);
      qy_q <= YW'(f_y);
      qz_q <= ZW'(f_z);
    end
    if (state_q == ST_OUT && !out_valid_q) begin
      out_mask_q  <= mask_q;
      out_id_q    <= id_q;
      out_total_q <= 3'($countones(mask_q));
    end
  end

  assign pres_req.start  = pres_start_q;
  assign pres_req.width  = map_w_q;
  assign pres_req.height = map_h_q;
  assign pres_req.pos    = pos_q;

  vfv_presence u_presence (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (pres_req),
    .rsp_o  (pres_rsp)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_total_q, out_id_q, out_mask_q};

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> state_q == ST_IDLE) else $error("item accepted while busy");
  a_write_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(vwe && bwe)) else $error("both memories written");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(out_mask_q) && $stable(out_id_q))
    else $error("result changed while waiting");
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> 32'(out_total_q) == $countones(out_mask_q))
    else $error("face total mismatch");
endmodule
